/* sv/rfrc_pkg.sv */
// Package: shared widths, codes and types for the RTU frame receiver/checker.
`timescale 1ns / 1ps
package rfrc_pkg;

   localparam int BYTE_W          = 8;
   localparam int WORD_W          = 16;
   localparam int CSR_INDEX_W     = 2;
   localparam int CSR_DATA_W      = 16;
   localparam int FRAME_DEPTH_DEF = 256;

   localparam logic [WORD_W-1:0] CRC_INIT         = 16'hFFFF;
   localparam logic [WORD_W-1:0] CRC_POLY         = 16'hA001;
   localparam logic [BYTE_W-1:0] FUNC_WRITE_MULTI = 8'h10;
   localparam logic [BYTE_W-1:0] IDLE_MAX         = 8'hFF;

   localparam logic [BYTE_W-1:0] STATION_ADDRESS_RST = 8'd1;
   localparam logic [WORD_W-1:0] UPDATE_START_RST    = 16'd0;
   localparam logic [BYTE_W-1:0] GAP_LIMIT_RST       = 8'd4;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_STATION_ADDRESS = 2'd0,
      CSR_UPDATE_START    = 2'd1,
      CSR_GAP_LIMIT       = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [BYTE_W-1:0] station_address;
      logic [WORD_W-1:0] update_start_address;
      logic [BYTE_W-1:0] gap_limit;
   } cfg_type;

   typedef struct packed {
      logic [BYTE_W-1:0] frame_length;
      logic              address_ok;
      logic              crc_ok;
      logic [BYTE_W-1:0] function_code;
      logic [WORD_W-1:0] first_word;
      logic              update_ack;
   } result_type;

endpackage

/* sv/rfrc_channels.sv */
// Interfaces: request (byte/tick) and response (frame report) channels.
`timescale 1ns / 1ps
interface rfrc_req_if;
   logic                      valid;
   logic                      ready;
   logic                      is_tick;
   logic [rfrc_pkg::BYTE_W-1:0] rx_byte;

   modport source (output valid, is_tick, rx_byte, input ready);
   modport sink   (input valid, is_tick, rx_byte, output ready);
endinterface

interface rfrc_rsp_if;
   logic                      valid;
   logic                      ready;
   logic [rfrc_pkg::BYTE_W-1:0] frame_length;
   logic                      address_ok;
   logic                      crc_ok;
   logic [rfrc_pkg::BYTE_W-1:0] function_code;
   logic [rfrc_pkg::WORD_W-1:0] first_word;
   logic                      update_ack;

   modport source (output valid, frame_length, address_ok, crc_ok, function_code,
                   first_word, update_ack, input ready);
   modport sink   (input valid, frame_length, address_ok, crc_ok, function_code,
                   first_word, update_ack, output ready);
endinterface

/* sv/rtu_frame_receiver_checker_top.sv */
// Top level: RTU frame receiver with CRC-16/MODBUS check and frame report.
//
// Usage:
//  - req_ch carries one word per item: is_tick=0 is a received byte (rx_byte),
//    is_tick=1 is one timer tick. Bytes build the current frame (running CRC,
//    byte count, address/function/first-word capture); ticks count idle time.
//  - When a tick arrives during a frame and the idle count has reached
//    gap_limit, one report word goes out on rsp_ch: length, address match,
//    CRC check, function code, first word and update acknowledge.
//  - A frame reaching FRAME_DEPTH bytes is dropped without a report.
//  - csr_* is a write-only register port: 0 station address, 1 update start
//    address, 2 gap limit. Write only while the block is idle.
//  - The report word is registered and valid in the cycle after the closing
//    tick is accepted. Throughput: one word per cycle when not stalled; all
//    per-word work: combinational byte CRC update plus frame state registers.
//  - Stall: the report sits in the output register; req_ch.ready drops only
//    while that register is full and rsp_ch.ready is low, and rises again in
//    the cycle the report is taken.
//  - Reset (synchronous): frame state cleared, CRC to 0xFFFF, registers to
//    address 1, update start 0, gap limit 4, output register empty.
`timescale 1ns / 1ps
module rtu_frame_receiver_checker_top #(
   parameter int FRAME_DEPTH = rfrc_pkg::FRAME_DEPTH_DEF
) (
   input  logic                             clock,
   input  logic                             reset,
   rfrc_req_if.sink                         req_ch,
   rfrc_rsp_if.source                       rsp_ch,
   input  logic                             csr_we,
   input  logic [rfrc_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [rfrc_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   import rfrc_pkg::*;

   cfg_type    cfg_ff;
   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_data_ff;
   result_type result;
   logic       result_fire;
   logic       req_step;

   // output register frees as it is read, so the input never waits on a
   // report that is leaving this cycle
   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign req_step     = req_ch.valid && req_ch.ready;

   rfrc_frame_tracker #(.FRAME_DEPTH(FRAME_DEPTH)) u_tracker (
      .clock       (clock),
      .reset       (reset),
      .step        (req_step),
      .is_tick     (req_ch.is_tick),
      .rx_byte     (req_ch.rx_byte),
      .cfg         (cfg_ff),
      .result_fire (result_fire),
      .result      (result)
   );

   // configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.station_address      <= STATION_ADDRESS_RST;
         cfg_ff.update_start_address <= UPDATE_START_RST;
         cfg_ff.gap_limit            <= GAP_LIMIT_RST;
      end else if (csr_we) begin
         case (csr_index_type'(csr_index))
            CSR_STATION_ADDRESS: cfg_ff.station_address      <= csr_wdata[BYTE_W-1:0];
            CSR_UPDATE_START:    cfg_ff.update_start_address <= csr_wdata[WORD_W-1:0];
            CSR_GAP_LIMIT:       cfg_ff.gap_limit            <= csr_wdata[BYTE_W-1:0];
            default:             ;
         endcase
      end
   end

   // report register
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (result_fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (result_fire) begin
         rsp_data_ff <= result;
      end
   end

   assign rsp_ch.valid         = rsp_valid_ff;
   assign rsp_ch.frame_length  = rsp_data_ff.frame_length;
   assign rsp_ch.address_ok    = rsp_data_ff.address_ok;
   assign rsp_ch.crc_ok        = rsp_data_ff.crc_ok;
   assign rsp_ch.function_code = rsp_data_ff.function_code;
   assign rsp_ch.first_word    = rsp_data_ff.first_word;
   assign rsp_ch.update_ack    = rsp_data_ff.update_ack;
endmodule

/* sv/rfrc_crc16.sv */
// CRC-16/MODBUS byte update (reflected poly, eight shift steps).
`timescale 1ns / 1ps
module rfrc_crc16 (
   input  logic [rfrc_pkg::WORD_W-1:0] crc_cur,
   input  logic [rfrc_pkg::BYTE_W-1:0] data,
   output logic [rfrc_pkg::WORD_W-1:0] crc_next
);
   import rfrc_pkg::*;

   always_comb begin
      logic [WORD_W-1:0] c;
      c = crc_cur ^ {{(WORD_W-BYTE_W){1'b0}}, data};
      for (int k = 0; k < BYTE_W; k++) begin
         if (c[0]) begin
            c = (c >> 1) ^ CRC_POLY;
         end else begin
            c = c >> 1;
         end
      end
      crc_next = c;
   end
endmodule

/* sv/rfrc_frame_tracker.sv */
// Frame tracker: per-byte state update, gap detection and frame report.
`timescale 1ns / 1ps
module rfrc_frame_tracker #(
   parameter int FRAME_DEPTH = rfrc_pkg::FRAME_DEPTH_DEF
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          step,
   input  logic                          is_tick,
   input  logic [rfrc_pkg::BYTE_W-1:0]   rx_byte,
   input  rfrc_pkg::cfg_type             cfg,
   output logic                          result_fire,
   output rfrc_pkg::result_type          result
);
   import rfrc_pkg::*;

   localparam int CNT_W = $clog2(FRAME_DEPTH);

   logic              active_ff, active_in;
   logic [BYTE_W-1:0] idle_ff, idle_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [WORD_W-1:0] crc_ff, crc_in;
   logic [BYTE_W-1:0] addr_ff, addr_in;
   logic [BYTE_W-1:0] func_ff, func_in;
   logic [WORD_W-1:0] word_ff, word_in;
   logic [WORD_W-1:0] crc_upd;
   logic              gap_hit;
   logic              long_enough;
   logic [WORD_W-1:0] word_out;

   rfrc_crc16 u_crc (
      .crc_cur  (crc_ff),
      .data     (rx_byte),
      .crc_next (crc_upd)
   );

   assign gap_hit     = idle_ff >= cfg.gap_limit;
   assign long_enough = count_ff >= CNT_W'(2);
   assign word_out    = (count_ff >= CNT_W'(4)) ? word_ff : '0;
   assign result_fire = step && is_tick && active_ff && gap_hit;

   always_comb begin
      result.frame_length  = BYTE_W'(count_ff);
      result.address_ok    = addr_ff == cfg.station_address;
      result.crc_ok        = long_enough && (crc_ff == '0);
      result.function_code = func_ff;
      result.first_word    = word_out;
      result.update_ack    = result.address_ok && result.crc_ok &&
                             (func_ff == FUNC_WRITE_MULTI) &&
                             (word_out == cfg.update_start_address);
   end

   always_comb begin
      active_in = active_ff;
      idle_in   = idle_ff;
      count_in  = count_ff;
      crc_in    = crc_ff;
      addr_in   = addr_ff;
      func_in   = func_ff;
      word_in   = word_ff;
      if (step) begin
         if (!is_tick) begin
            active_in = 1'b1;
            idle_in   = '0;
            crc_in    = crc_upd;
            case (count_ff)
               CNT_W'(0): addr_in = rx_byte;
               CNT_W'(1): func_in = rx_byte;
               CNT_W'(2): word_in = {rx_byte, word_ff[BYTE_W-1:0]};
               CNT_W'(3): word_in = {word_ff[WORD_W-1:BYTE_W], rx_byte};
               default:   ;
            endcase
            if (count_ff == CNT_W'(FRAME_DEPTH-1)) begin
               // buffer full: drop the frame silently
               active_in = 1'b0;
               count_in  = '0;
               crc_in    = CRC_INIT;
               addr_in   = '0;
               func_in   = '0;
               word_in   = '0;
            end else begin
               count_in = count_ff + CNT_W'(1);
            end
         end else if (!active_ff) begin
            idle_in = '0;
         end else if (gap_hit) begin
            active_in = 1'b0;
            idle_in   = '0;
            count_in  = '0;
            crc_in    = CRC_INIT;
            addr_in   = '0;
            func_in   = '0;
            word_in   = '0;
         end else if (idle_ff != IDLE_MAX) begin
            idle_in = idle_ff + BYTE_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= 1'b0;
         idle_ff   <= '0;
         count_ff  <= '0;
         crc_ff    <= CRC_INIT;
         addr_ff   <= '0;
         func_ff   <= '0;
         word_ff   <= '0;
      end else begin
         active_ff <= active_in;
         idle_ff   <= idle_in;
         count_ff  <= count_in;
         crc_ff    <= crc_in;
         addr_ff   <= addr_in;
         func_ff   <= func_in;
         word_ff   <= word_in;
      end
   end
endmodule

/* sv/rfrc_checker.sv */
// Checker: port-level assertions for the frame receiver, bound to the top.
`timescale 1ns / 1ps
module rfrc_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_ready,
   input logic                          req_is_tick,
   input logic                          rsp_valid,
   input logic                          rsp_ready,
   input logic [rfrc_pkg::BYTE_W-1:0]   rsp_frame_length,
   input logic                          rsp_address_ok,
   input logic                          rsp_crc_ok,
   input logic [rfrc_pkg::BYTE_W-1:0]   rsp_function_code,
   input logic                          rsp_update_ack
);
   import rfrc_pkg::*;

   // a stalled report holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_frame_length))
      else $error("report dropped or changed under stall");

   // input only waits behind a pending report
   a_ready: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("input stalled with empty output");

   // a byte never produces a report
   a_byte_no_rsp: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready && !req_is_tick && !(rsp_valid && !rsp_ready)
      |=> !rsp_valid)
      else $error("report after a byte");

   // crc check needs two bytes
   a_crc_len: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_crc_ok |-> rsp_frame_length >= BYTE_W'(2))
      else $error("crc ok on short frame");

   // update ack implies its conditions
   a_ack: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_update_ack |->
         rsp_address_ok && rsp_crc_ok && rsp_function_code == FUNC_WRITE_MULTI)
      else $error("update ack without its conditions");
endmodule

bind rtu_frame_receiver_checker_top rfrc_checker u_rfrc_checker (
   .clock             (clock),
   .reset             (reset),
   .req_valid         (req_ch.valid),
   .req_ready         (req_ch.ready),
   .req_is_tick       (req_ch.is_tick),
   .rsp_valid         (rsp_ch.valid),
   .rsp_ready         (rsp_ch.ready),
   .rsp_frame_length  (rsp_ch.frame_length),
   .rsp_address_ok    (rsp_ch.address_ok),
   .rsp_crc_ok        (rsp_ch.crc_ok),
   .rsp_function_code (rsp_ch.function_code),
   .rsp_update_ack    (rsp_ch.update_ack)
);
